@@ hdl/gre_pkg.sv @@
package gre_pkg;

    localparam int VTX_W            = 6;
    localparam int NUM_VERTICES_DEF = 64;
    localparam int MAX_DEGREE_DEF   = 8;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
    } req_t;

    typedef struct packed {
        logic reachable;
        logic status;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // take request word, read degree of vertex_a
        logic sweep_deg;   // clear one degree entry
        logic sweep_vis;   // clear one visited mark
        logic rd_deg_b;    // keep degree of a, read degree of b
        logic wr_first;    // append to a's list
        logic wr_second;   // append to b's list (second slot for a self loop)
        logic seed;        // mark source, push it
        logic pop;         // pop top of stack
        logic rd_vdeg;     // read degree of popped vertex
        logic cap_vdeg;    // latch degree, restart slot count
        logic rd_nbr;      // read next neighbor entry
        logic rd_vis;      // read visited mark of that neighbor
        logic push;        // push neighbor if unvisited
        logic set_reach;
        logic set_refuse;
        logic finish;      // load output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sweep_last;
        logic range_ok;
        logic same;
        logic add_fits;
        logic stack_empty;
        logic scan_done;
        logic n_hit;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/gre_ctrl.sv @@
module gre_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_kind,
    output logic          req_stall,
    output gre_pkg::cmd_t cmd,
    input  gre_pkg::sts_t sts
);
    import gre_pkg::*;

    typedef enum logic [15:0] {
        S_INIT    = 16'h0001,
        S_IDLE    = 16'h0002,
        S_A_RDB   = 16'h0004,
        S_A_CHK   = 16'h0008,
        S_A_WR1   = 16'h0010,
        S_A_WR2   = 16'h0020,
        S_Q_CHK   = 16'h0040,
        S_Q_CLR   = 16'h0080,
        S_Q_SEED  = 16'h0100,
        S_Q_POP   = 16'h0200,
        S_Q_VTX   = 16'h0400,
        S_Q_DEG   = 16'h0800,
        S_Q_NRD   = 16'h1000,
        S_Q_NCHK  = 16'h2000,
        S_Q_NPUSH = 16'h4000,
        S_DONE    = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep_deg = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_kind == KIND_ADD) ? S_A_RDB : S_Q_CHK;
                end
            end
            S_A_RDB:
            begin
                if (!sts.range_ok)
                begin
                    cmd.set_refuse = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_deg_b = 1'b1;
                    state_next   = S_A_CHK;
                end
            end
            S_A_CHK:
            begin
                if (sts.add_fits)
                begin
                    state_next = S_A_WR1;
                end
                else
                begin
                    cmd.set_refuse = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_A_WR1:
            begin
                cmd.wr_first = 1'b1;
                state_next   = S_A_WR2;
            end
            S_A_WR2:
            begin
                cmd.wr_second = 1'b1;
                state_next    = S_DONE;
            end
            S_Q_CHK:
            begin
                if (!sts.range_ok)
                begin
                    state_next = S_DONE;
                end
                else if (sts.same)
                begin
                    cmd.set_reach = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_Q_CLR;
                end
            end
            S_Q_CLR:
            begin
                cmd.sweep_vis = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_Q_SEED;
                end
            end
            S_Q_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = S_Q_POP;
            end
            S_Q_POP:
            begin
                if (sts.stack_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_Q_VTX;
                end
            end
            S_Q_VTX:
            begin
                cmd.rd_vdeg = 1'b1;
                state_next  = S_Q_DEG;
            end
            S_Q_DEG:
            begin
                cmd.cap_vdeg = 1'b1;
                state_next   = S_Q_NRD;
            end
            S_Q_NRD:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_Q_POP;
                end
                else
                begin
                    cmd.rd_nbr = 1'b1;
                    state_next = S_Q_NCHK;
                end
            end
            S_Q_NCHK:
            begin
                if (sts.n_hit)
                begin
                    cmd.set_reach = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_vis = 1'b1;
                    state_next = S_Q_NPUSH;
                end
            end
            S_Q_NPUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_Q_NRD;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while previous word still in work");

    a_finish_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == S_IDLE))
        else $error("finish did not return to idle");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register lost its one-hot code");

endmodule

@@ hdl/gre_datapath.sv @@
module gre_datapath #(
    parameter int NUM_VERTICES = gre_pkg::NUM_VERTICES_DEF,
    parameter int MAX_DEGREE   = gre_pkg::MAX_DEGREE_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  gre_pkg::req_t req,
    input  gre_pkg::cmd_t cmd,
    output gre_pkg::sts_t sts,
    output gre_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_stall
);
    import gre_pkg::*;

    localparam int AW  = $clog2(NUM_VERTICES);
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int SPW = $clog2(NUM_VERTICES + 1);
    localparam int NAW = $clog2(NUM_VERTICES * MAX_DEGREE);

    // memories
    logic [DW-1:0]    deg_mem [NUM_VERTICES];
    logic [VTX_W-1:0] nbr_mem [NUM_VERTICES*MAX_DEGREE];
    logic             vis_mem [NUM_VERTICES];
    logic [AW-1:0]    stk_mem [NUM_VERTICES];

    logic [DW-1:0]    deg_rd_reg;
    logic [VTX_W-1:0] nbr_rd_reg;
    logic             vis_rd_reg;
    logic [AW-1:0]    stk_rd_reg;

    // control registers
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // payload registers
    logic [VTX_W-1:0] a_reg, b_reg;
    logic [DW-1:0]    deg_a_reg, deg_b_reg, deg_v_reg, slot_reg;
    logic [AW-1:0]    v_reg;
    logic             res_reach_reg, res_stat_reg;
    rsp_t             rsp_reg;

    logic             deg_we, deg_re;
    logic [AW-1:0]    deg_waddr, deg_raddr;
    logic [DW-1:0]    deg_wdata;
    logic             nbr_we;
    logic [NAW-1:0]   nbr_waddr, nbr_raddr;
    logic [VTX_W-1:0] nbr_wdata;
    logic             vis_we;
    logic [AW-1:0]    vis_waddr;
    logic             stk_we;
    logic [AW-1:0]    stk_waddr;
    logic [SPW-1:0]   sp_dec;
    logic             push_go;
    logic             n_ok;

    function automatic logic [NAW-1:0] slot_addr(input logic [VTX_W-1:0] vtx,
                                                 input logic [DW-1:0] slot);
        slot_addr = NAW'(vtx) * NAW'(MAX_DEGREE) + NAW'(slot);
    endfunction

    assign sp_dec  = sp_reg - SPW'(1);
    assign n_ok    = (32'(nbr_rd_reg) < NUM_VERTICES);
    assign push_go = cmd.push && !vis_rd_reg && n_ok && (32'(sp_reg) < NUM_VERTICES);

    always_comb
    begin
        deg_we    = cmd.sweep_deg || cmd.wr_first || (cmd.wr_second && (a_reg != b_reg));
        deg_waddr = AW'(b_reg);
        deg_wdata = deg_b_reg + DW'(1);
        if (cmd.sweep_deg)
        begin
            deg_waddr = cnt_reg;
            deg_wdata = '0;
        end
        else if (cmd.wr_first)
        begin
            deg_waddr = AW'(a_reg);
            deg_wdata = deg_a_reg + ((a_reg == b_reg) ? DW'(2) : DW'(1));
        end

        deg_re    = cmd.load || cmd.rd_deg_b || cmd.rd_vdeg;
        deg_raddr = stk_rd_reg;
        if (cmd.load)
        begin
            deg_raddr = AW'(req.vertex_a);
        end
        else if (cmd.rd_deg_b)
        begin
            deg_raddr = AW'(b_reg);
        end

        nbr_we    = cmd.wr_first || cmd.wr_second;
        nbr_wdata = cmd.wr_first ? b_reg : a_reg;
        if (cmd.wr_first)
        begin
            nbr_waddr = slot_addr(a_reg, deg_a_reg);
        end
        else if (a_reg == b_reg)
        begin
            // self loop takes the next slot too
            nbr_waddr = slot_addr(a_reg, deg_a_reg) + NAW'(1);
        end
        else
        begin
            nbr_waddr = slot_addr(b_reg, deg_b_reg);
        end
        nbr_raddr = NAW'(v_reg) * NAW'(MAX_DEGREE) + NAW'(slot_reg);

        vis_we    = cmd.sweep_vis || cmd.seed || push_go;
        vis_waddr = AW'(nbr_rd_reg);
        if (cmd.sweep_vis)
        begin
            vis_waddr = cnt_reg;
        end
        else if (cmd.seed)
        begin
            vis_waddr = AW'(a_reg);
        end

        stk_we    = cmd.seed || push_go;
        stk_waddr = cmd.seed ? '0 : sp_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (deg_re)
        begin
            deg_rd_reg <= deg_mem[deg_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nbr_we)
        begin
            nbr_mem[nbr_waddr] <= nbr_wdata;
        end
        if (cmd.rd_nbr)
        begin
            nbr_rd_reg <= nbr_mem[nbr_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= !cmd.sweep_vis;
        end
        if (cmd.rd_vis)
        begin
            vis_rd_reg <= vis_mem[AW'(nbr_rd_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= cmd.seed ? AW'(a_reg) : AW'(nbr_rd_reg);
        end
        if (cmd.pop)
        begin
            stk_rd_reg <= stk_mem[sp_dec[AW-1:0]];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = '0;
        end
        else if (cmd.sweep_deg || cmd.sweep_vis)
        begin
            cnt_next = sts.sweep_last ? '0 : cnt_reg + AW'(1);
        end

        sp_next = sp_reg;
        if (cmd.seed)
        begin
            sp_next = SPW'(1);
        end
        else if (cmd.pop)
        begin
            sp_next = sp_dec;
        end
        else if (push_go)
        begin
            sp_next = sp_reg + SPW'(1);
        end

        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sp_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            sp_reg        <= sp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg         <= req.vertex_a;
            b_reg         <= req.vertex_b;
            res_reach_reg <= 1'b0;
            res_stat_reg  <= STATUS_OK;
        end
        if (cmd.set_reach)
        begin
            res_reach_reg <= 1'b1;
        end
        if (cmd.set_refuse)
        begin
            res_stat_reg <= STATUS_REFUSED;
        end
        if (cmd.rd_deg_b)
        begin
            deg_a_reg <= deg_rd_reg;
        end
        if (cmd.set_refuse || cmd.rd_deg_b || cmd.wr_first)
        begin
            // degree of b arrives the cycle after rd_deg_b
            deg_b_reg <= deg_rd_reg;
        end
        if (cmd.rd_vdeg)
        begin
            v_reg <= stk_rd_reg;
        end
        if (cmd.cap_vdeg)
        begin
            deg_v_reg <= (32'(deg_rd_reg) > MAX_DEGREE) ? DW'(MAX_DEGREE) : deg_rd_reg;
            slot_reg  <= '0;
        end
        else if (cmd.rd_nbr)
        begin
            slot_reg <= slot_reg + DW'(1);
        end
        if (cmd.finish)
        begin
            rsp_reg.reachable <= res_reach_reg;
            rsp_reg.status    <= res_stat_reg;
        end
    end

    always_comb
    begin
        sts.sweep_last  = (32'(cnt_reg) == NUM_VERTICES - 1);
        sts.range_ok    = (32'(a_reg) < NUM_VERTICES) && (32'(b_reg) < NUM_VERTICES);
        sts.same        = (a_reg == b_reg);
        if (a_reg == b_reg)
        begin
            sts.add_fits = (32'(deg_a_reg) + 2 <= MAX_DEGREE);
        end
        else
        begin
            sts.add_fits = (32'(deg_a_reg) < MAX_DEGREE) && (32'(deg_rd_reg) < MAX_DEGREE);
        end
        sts.stack_empty = (sp_reg == '0);
        sts.scan_done   = (slot_reg == deg_v_reg);
        sts.n_hit       = (nbr_rd_reg == b_reg);
        sts.out_free    = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) <= NUM_VERTICES)
        else $error("walk stack overflow");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(rsp_valid_reg && rsp_stall))
        else $error("result register overwritten while stalled");

    a_degree_bound: assert property (@(posedge clk) disable iff (!rst_n)
        deg_we |-> (32'(deg_wdata) <= MAX_DEGREE))
        else $error("adjacency list grew past its bound");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_nbr |-> (slot_reg < deg_v_reg))
        else $error("neighbor scan past list end");

endmodule

@@ hdl/graph_reachability_engine.sv @@
// Add word: both degrees are read and checked, then both list entries are written;
//   query: range check, visited sweep, then a depth-first walk of popped vertices.
// One word in work at a time; the next is taken once the result is registered.
// Rate is set by the single read port of the neighbor and visited memories.
// After reset the degree memory is swept to zero, one entry a cycle, and no
//   request is taken until the sweep has reached the last entry.
module graph_reachability_engine #(
    parameter int NUM_VERTICES = gre_pkg::NUM_VERTICES_DEF,
    parameter int MAX_DEGREE   = gre_pkg::MAX_DEGREE_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  gre_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output gre_pkg::rsp_t rsp
);
    import gre_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    gre_datapath #(
        .NUM_VERTICES (NUM_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

endmodule
